FILE: sv/ipa_pkg.sv
// ============================================================================
// ipa_pkg: shared definitions for the slot index pool allocator
// Holds the default sizing, field widths, operation and status codes and the
// command and status bundles exchanged between controller and datapath.
// ============================================================================
`default_nettype none

package ipa_pkg;

    // Default sizing of the allocator.
    localparam int MAX_SLOTS_DEF  = 1024;
    localparam int POOL_COUNT_DEF = 4;

    // Fixed field widths of the streaming and configuration ports.
    localparam int MODE_W   = 2;
    localparam int POOL_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 11;
    localparam int CFG_AW   = 2;
    localparam int IN_TW    = 16;
    localparam int OUT_TW   = 16;

    // Operation requested by an input transaction.
    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_APPLY   = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    // Result status reported with every output transaction.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_ABSENT = 3'd2,
        ST_RANGE  = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FINISH,
        S_AP_READ,
        S_AP_WRITE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic ap_read;   // read the next pending entry of the current pool
        logic ap_write;  // push the pending entry just read onto the free stack
        logic ap_next;   // close the current pool's list and move to the next pool
        logic load_out;  // move the finished result into the output register
    } ipa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_apply;  // offered input item is an apply
        logic pools_done;   // apply walk has passed the last pool
        logic list_done;    // current pool's pending list fully moved
        logic out_free;     // output register can take a result this cycle
    } ipa_sts_t;

endpackage

`default_nettype wire

FILE: sv/ipa_ctrl.sv
// ============================================================================
// ipa_ctrl: sequencer of the slot index pool allocator
// Accepts transactions, steps the pending-release walk of an apply and hands
// finished results to the output register.
// ============================================================================
`default_nettype none

module ipa_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire ipa_pkg::ipa_sts_t sts,
    output ipa_pkg::ipa_cmd_t      cmd
);

    ipa_pkg::ctrl_state_t state_reg;
    ipa_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        cfg_ready     = 1'b0;
        unique case (state_reg)
            ipa_pkg::S_IDLE:
            begin
                // A register write goes first when both sides offer at once.
                cfg_ready     = 1'b1;
                s_axis_tready = !cfg_valid;
                if (s_axis_tvalid && !cfg_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_is_apply ? ipa_pkg::S_AP_READ
                                                 : ipa_pkg::S_FINISH;
                end
            end
            ipa_pkg::S_AP_READ:
            begin
                if (sts.pools_done)
                begin
                    state_next = ipa_pkg::S_FINISH;
                end
                else if (sts.list_done)
                begin
                    cmd.ap_next = 1'b1;
                end
                else
                begin
                    cmd.ap_read = 1'b1;
                    state_next  = ipa_pkg::S_AP_WRITE;
                end
            end
            ipa_pkg::S_AP_WRITE:
            begin
                cmd.ap_write = 1'b1;
                state_next   = ipa_pkg::S_AP_READ;
            end
            ipa_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ipa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ipa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/ipa_dp.sv
// ============================================================================
// ipa_dp: datapath of the slot index pool allocator
// Pool registers, free stack and pending list memories, the apply walk
// counters and the result and output registers.
// ============================================================================
`default_nettype none

module ipa_dp
#(
    parameter int MAX_SLOTS  = ipa_pkg::MAX_SLOTS_DEF,
    parameter int POOL_COUNT = ipa_pkg::POOL_COUNT_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [ipa_pkg::IN_TW-1:0]   s_axis_tdata,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [ipa_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [ipa_pkg::SIZE_W-1:0]  cfg_data,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [ipa_pkg::OUT_TW-1:0]       m_axis_tdata,
    input  wire ipa_pkg::ipa_cmd_t           cmd,
    output ipa_pkg::ipa_sts_t                sts
);

    localparam int AW    = $clog2(MAX_SLOTS);
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int APW   = $clog2(POOL_COUNT + 1);
    localparam int MAW   = PW + AW;
    localparam int DEPTH = 1 << MAW;

    // ---------------------------------------------------------------- fields
    ipa_pkg::mode_t              in_mode;
    logic [ipa_pkg::POOL_W-1:0]  in_pool;
    logic [ipa_pkg::SLOT_W-1:0]  in_slot;

    assign in_mode = ipa_pkg::mode_t'(s_axis_tdata[1:0]);
    assign in_pool = s_axis_tdata[3:2];
    assign in_slot = s_axis_tdata[13:4];

    // ------------------------------------------------------- pool registers
    // lim marks the lowest stack position written since the last refill;
    // every position below it still holds its own index.
    logic [CW-1:0] size_reg [POOL_COUNT];
    logic [CW-1:0] size_next[POOL_COUNT];
    logic [CW-1:0] fc_reg   [POOL_COUNT];
    logic [CW-1:0] fc_next  [POOL_COUNT];
    logic [CW-1:0] pc_reg   [POOL_COUNT];
    logic [CW-1:0] pc_next  [POOL_COUNT];
    logic [CW-1:0] lim_reg  [POOL_COUNT];
    logic [CW-1:0] lim_next [POOL_COUNT];

    logic [APW-1:0] ap_reg;
    logic [APW-1:0] ap_next;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  k_next;

    // Result waiting for the output register.
    ipa_pkg::status_t            res_status_reg;
    ipa_pkg::status_t            res_status_next;
    logic                        res_alloc_reg;
    logic                        res_alloc_next;
    logic                        res_fill_reg;
    logic                        res_fill_next;
    logic [ipa_pkg::SLOT_W-1:0]  res_fill_val_reg;
    logic [ipa_pkg::SLOT_W-1:0]  res_fill_val_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ipa_pkg::OUT_TW-1:0]  out_data_reg;
    logic [ipa_pkg::OUT_TW-1:0]  out_data_next;

    // ------------------------------------------------------------- memories
    logic [ipa_pkg::SLOT_W-1:0] free_mem [DEPTH];
    logic [ipa_pkg::SLOT_W-1:0] pend_mem [DEPTH];
    logic [ipa_pkg::SLOT_W-1:0] free_rd_reg;
    logic [ipa_pkg::SLOT_W-1:0] pend_rd_reg;

    logic                       free_rd_en;
    logic [MAW-1:0]             free_rd_addr;
    logic                       free_wr_en;
    logic [MAW-1:0]             free_wr_addr;
    logic                       pend_rd_en;
    logic [MAW-1:0]             pend_rd_addr;
    logic                       pend_wr_en;
    logic [MAW-1:0]             pend_wr_addr;

    // ------------------------------------------------------ pool selection
    logic [PW-1:0]  pi;
    logic           pool_in;
    logic [CW-1:0]  size_sel;
    logic [CW-1:0]  fc_sel;
    logic [CW-1:0]  pc_sel;
    logic [CW-1:0]  lim_sel;
    logic [CW-1:0]  fc_m1;
    logic [CW:0]    used_sum;
    logic [PW-1:0]  api;
    logic [PW-1:0]  cfg_pi;
    logic [CW-1:0]  cfg_size;
    logic           cfg_hit;

    assign pi       = PW'(in_pool);
    assign pool_in  = (32'(in_pool) < POOL_COUNT);
    assign size_sel = pool_in ? size_reg[pi] : '0;
    assign fc_sel   = pool_in ? fc_reg[pi]   : '0;
    assign pc_sel   = pool_in ? pc_reg[pi]   : '0;
    assign lim_sel  = pool_in ? lim_reg[pi]  : '0;
    assign fc_m1    = fc_sel - CW'(1);
    assign used_sum = {1'b0, fc_sel} + {1'b0, pc_sel};
    assign api      = PW'(ap_reg);

    assign cfg_pi   = PW'(cfg_addr);
    assign cfg_hit  = cfg_valid && cfg_ready && (32'(cfg_addr) < POOL_COUNT);
    assign cfg_size = (32'(cfg_data) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cfg_data);

    assign sts.in_is_apply = (in_mode == ipa_pkg::MODE_APPLY);
    assign sts.pools_done  = (ap_reg == APW'(POOL_COUNT));
    assign sts.list_done   = (k_reg == pc_reg[api]);
    assign sts.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------------------------------------------------- next state
    always_comb
    begin
        size_next         = size_reg;
        fc_next           = fc_reg;
        pc_next           = pc_reg;
        lim_next          = lim_reg;
        ap_next           = ap_reg;
        k_next            = k_reg;
        res_status_next   = res_status_reg;
        res_alloc_next    = res_alloc_reg;
        res_fill_next     = res_fill_reg;
        res_fill_val_next = res_fill_val_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        free_rd_en        = 1'b0;
        free_rd_addr      = {pi, AW'(fc_m1)};
        free_wr_en        = 1'b0;
        free_wr_addr      = {api, AW'(fc_reg[api])};
        pend_rd_en        = 1'b0;
        pend_rd_addr      = {api, AW'(k_reg)};
        pend_wr_en        = 1'b0;
        pend_wr_addr      = {pi, AW'(pc_sel)};

        if (cfg_hit)
        begin
            size_next[cfg_pi] = cfg_size;
            fc_next[cfg_pi]   = cfg_size;
            lim_next[cfg_pi]  = cfg_size;
            pc_next[cfg_pi]   = '0;
        end

        if (cmd.accept)
        begin
            res_status_next   = ipa_pkg::ST_OK;
            res_alloc_next    = 1'b0;
            res_fill_next     = (fc_m1 < lim_sel);
            res_fill_val_next = ipa_pkg::SLOT_W'(fc_m1);
            unique case (in_mode)
                ipa_pkg::MODE_ALLOC:
                begin
                    if (!pool_in || size_sel == '0)
                    begin
                        res_status_next = ipa_pkg::ST_ABSENT;
                    end
                    else if (fc_sel == '0)
                    begin
                        res_status_next = ipa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_alloc_next = 1'b1;
                        free_rd_en     = 1'b1;
                        fc_next[pi]    = fc_m1;
                    end
                end
                ipa_pkg::MODE_RELEASE:
                begin
                    if (!pool_in || size_sel == '0)
                    begin
                        res_status_next = ipa_pkg::ST_ABSENT;
                    end
                    else if (32'(in_slot) >= 32'(size_sel))
                    begin
                        res_status_next = ipa_pkg::ST_RANGE;
                    end
                    else if (used_sum >= {1'b0, size_sel})
                    begin
                        res_status_next = ipa_pkg::ST_FULL;
                    end
                    else
                    begin
                        pend_wr_en  = 1'b1;
                        pc_next[pi] = pc_sel + CW'(1);
                    end
                end
                ipa_pkg::MODE_APPLY:
                begin
                    ap_next = '0;
                    k_next  = '0;
                end
                ipa_pkg::MODE_NOP:
                begin
                    res_status_next = ipa_pkg::ST_OK;
                end
                default:
                begin
                    res_status_next = ipa_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.ap_read)
        begin
            pend_rd_en = 1'b1;
            k_next     = k_reg + CW'(1);
        end

        if (cmd.ap_write)
        begin
            free_wr_en   = 1'b1;
            fc_next[api] = fc_reg[api] + CW'(1);
            if (fc_reg[api] < lim_reg[api])
            begin
                lim_next[api] = fc_reg[api];
            end
        end

        if (cmd.ap_next)
        begin
            pc_next[api] = '0;
            ap_next      = ap_reg + APW'(1);
            k_next       = '0;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[ipa_pkg::STATUS_W-1:0] = res_status_reg;
            if (res_alloc_reg)
            begin
                out_data_next[ipa_pkg::STATUS_W +: ipa_pkg::SLOT_W] =
                    res_fill_reg ? res_fill_val_reg : free_rd_reg;
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < POOL_COUNT; p++)
            begin
                size_reg[p] <= '0;
                fc_reg[p]   <= '0;
                pc_reg[p]   <= '0;
                lim_reg[p]  <= '0;
            end
            ap_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            fc_reg        <= fc_next;
            pc_reg        <= pc_next;
            lim_reg       <= lim_next;
            ap_reg        <= ap_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg   <= res_status_next;
        res_alloc_reg    <= res_alloc_next;
        res_fill_reg     <= res_fill_next;
        res_fill_val_reg <= res_fill_val_next;
        out_data_reg     <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (free_wr_en)
        begin
            free_mem[free_wr_addr] <= pend_rd_reg;
        end
        if (free_rd_en)
        begin
            free_rd_reg <= free_mem[free_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_wr_en)
        begin
            pend_mem[pend_wr_addr] <= in_slot;
        end
        if (pend_rd_en)
        begin
            pend_rd_reg <= pend_mem[pend_rd_addr];
        end
    end

    // ----------------------------------------------------------- assertions
    // The free count, the pending count and the fill mark each stay within
    // the pool size. During an apply walk the pending count of the pool
    // being walked is only cleared at its end, so their sum may exceed it.
    for (genvar g = 0; g < POOL_COUNT; g++)
    begin : g_pool_chk
        a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
            (fc_reg[g] <= size_reg[g]) && (pc_reg[g] <= size_reg[g]) &&
            (lim_reg[g] <= size_reg[g]))
            else $error("pool counters exceed pool size");
    end

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ap_write |-> $past(cmd.ap_read))
        else $error("free stack push without a pending read before it");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_axis_tready))
        else $error("result loaded over an untaken output");

endmodule

`default_nettype wire

FILE: sv/index_pool_allocator_deferred_free.sv
// ============================================================================
// index_pool_allocator_deferred_free: slot index pools with deferred release
// Keeps POOL_COUNT pools, each with a free stack and a pending-release list.
// Allocate pops a free index, release queues an index, apply returns every
// queued index to its pool's free stack in order.
// ============================================================================
//
// Channel  Direction  Handshake                   Payload
// -------  ---------  --------------------------  ------------------------------
// s_axis   in         s_axis_tvalid/tready        mode, pool, slot_index
// m_axis   out        m_axis_tvalid/tready        status, granted_index
// cfg      in         cfg_valid/cfg_ready         cfg_addr (register), cfg_data
//
// Allocate, release and the unused mode pass through the accept cycle (which
// starts the free stack read of an allocate) and a finish cycle that loads
// the output register. Apply walks the pools one by one after the accept;
// each pending entry costs a pending-list read followed by a free-stack
// write of the registered read data, and a finish cycle then loads the
// output register.
// Reset clears all counters and sizes at once; no clearing pass is needed,
// since a refill is tracked by a per-pool mark below which every stack
// position still reads as its own index.
// A stalled output holds the result in the finish cycle; no new transaction
// is taken until that result reaches the output register.
// ============================================================================
`default_nettype none

module index_pool_allocator_deferred_free
#(
    parameter int MAX_SLOTS  = ipa_pkg::MAX_SLOTS_DEF,
    parameter int POOL_COUNT = ipa_pkg::POOL_COUNT_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input transactions.
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] mode, [3:2] pool, [13:4] slot_index, [15:14] zero
    input  wire logic [ipa_pkg::IN_TW-1:0]   s_axis_tdata,
    // Result transactions.
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [2:0] status, [12:3] granted_index, [15:13] zero
    output logic [ipa_pkg::OUT_TW-1:0]       m_axis_tdata,
    // Register writes: index i selects pool_size_i.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ipa_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [ipa_pkg::SIZE_W-1:0]  cfg_data
);

    // Commands travel from the controller to the datapath, status back.
    ipa_pkg::ipa_cmd_t cmd;
    ipa_pkg::ipa_sts_t sts;

    // The controller owns every handshake decision: when a transaction is
    // taken, how an apply walks the pools, and when a result is handed on.
    ipa_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // The datapath holds the pool counters, both memories and the output
    // register, and carries out the commands it is given.
    ipa_dp
    #(
        .MAX_SLOTS  (MAX_SLOTS),
        .POOL_COUNT (POOL_COUNT)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

FILE: sim/index_pool_allocator_deferred_free_test.sv
// ============================================================================
// index_pool_allocator_deferred_free_test: self-checking bench for the pools
// Drives allocate, release, apply and unused-mode commands into the slot
// index allocator and checks every result against an in-bench model of the
// free stacks and pending-release lists. Pool sizes are rewritten between
// phases, and both stream sides idle at random.
// ============================================================================
`default_nettype none

module index_pool_allocator_deferred_free_test;

    import ipa_pkg::*;

    localparam int MAX_SLOTS  = MAX_SLOTS_DEF;
    localparam int POOL_COUNT = POOL_COUNT_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_GAP = 18;
    // An apply walks every pending entry with no transaction on any port; the
    // watchdog allows several times the longest such walk, with all pools
    // full of pending entries.
    localparam int WATCHDOG_LIMIT = 40000;
    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int ITEMS_PER_PHASE = 125;

    // One expected result transaction.
    typedef struct {
        status_t               status;
        logic [SLOT_W-1:0]     granted;
    } alloc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [1:0] mode, [3:2] pool, [13:4] slot_index, [15:14] zero
    logic [IN_TW-1:0]      s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [2:0] status, [12:3] granted_index, [15:13] zero
    logic [OUT_TW-1:0]     m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_AW-1:0]     cfg_addr;
    logic [SIZE_W-1:0]     cfg_data;

    // Model state: one free stack and one pending list per pool.
    logic [SLOT_W-1:0]     free_stack_m [POOL_COUNT][MAX_SLOTS];
    logic [SLOT_W-1:0]     pending_m [POOL_COUNT][MAX_SLOTS];
    int unsigned           free_cnt_m [POOL_COUNT];
    int unsigned           pending_cnt_m [POOL_COUNT];
    int unsigned           pool_len_m [POOL_COUNT];

    // Results predicted but not yet seen on the output stream, oldest first.
    alloc_result_t         expected_results [$];
    // Indices granted by the block and not yet released, per pool. The
    // random traffic draws most of its releases from here.
    logic [SLOT_W-1:0]     held_slots [POOL_COUNT][$];

    int                    errors;
    int                    items_sent;
    int                    directed_items;
    int                    results_seen;
    int                    cfg_writes;
    int                    random_phases;
    int                    idle_cycles;
    bit                    send_rush;
    bit                    recv_rush;

    index_pool_allocator_deferred_free DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the allocator.
    // ------------------------------------------------------------------------

    // A size write saturates at MAX_SLOTS, refills the free stack in rising
    // order so the highest index sits on top, and drops the pending list.
    function automatic void set_pool_size(input logic [CFG_AW-1:0] idx,
                                          input logic [SIZE_W-1:0] value);
        int unsigned n;
        n = (value > MAX_SLOTS) ? MAX_SLOTS : value;
        pool_len_m[idx] = n;
        for (int k = 0; k < n; k++)
        begin
            free_stack_m[idx][k] = k[SLOT_W-1:0];
        end
        free_cnt_m[idx] = n;
        pending_cnt_m[idx] = 0;
    endfunction

    function automatic void allocator_predict(input mode_t mode,
                                              input logic [POOL_W-1:0] pool,
                                              input logic [SLOT_W-1:0] slot,
                                              output status_t st,
                                              output logic [SLOT_W-1:0] grant);
        st = ST_OK;
        grant = '0;
        if (mode == MODE_ALLOC || mode == MODE_RELEASE)
        begin
            if (pool >= POOL_COUNT || pool_len_m[pool] == 0)
            begin
                st = ST_ABSENT;
            end
            else if (mode == MODE_ALLOC)
            begin
                if (free_cnt_m[pool] == 0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    free_cnt_m[pool]--;
                    grant = free_stack_m[pool][free_cnt_m[pool]];
                end
            end
            else if (slot >= pool_len_m[pool])
            begin
                st = ST_RANGE;
            end
            else if (free_cnt_m[pool] + pending_cnt_m[pool] >= pool_len_m[pool])
            begin
                // Refusing here keeps a later apply from overflowing the stack.
                st = ST_FULL;
            end
            else
            begin
                pending_m[pool][pending_cnt_m[pool]] = slot;
                pending_cnt_m[pool]++;
            end
        end
        else if (mode == MODE_APPLY)
        begin
            // Every pool's pending entries go onto its free stack in the
            // order they were released, so the last released is on top.
            for (int p = 0; p < POOL_COUNT; p++)
            begin
                for (int k = 0; k < pending_cnt_m[p]; k++)
                begin
                    if (free_cnt_m[p] < MAX_SLOTS)
                    begin
                        free_stack_m[p][free_cnt_m[p]] = pending_m[p][k];
                        free_cnt_m[p]++;
                    end
                end
                pending_cnt_m[p] = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------------

    // Sends one command transaction. It is entered and left at a falling
    // edge. The valid is left high on return so that a following command
    // with no gap goes out back to back; any task that lets time pass
    // without sending lowers it first.
    task automatic send_command(input mode_t mode, input logic [POOL_W-1:0] pool,
                                input logic [SLOT_W-1:0] slot,
                                output status_t st, output logic [SLOT_W-1:0] grant);
        int gap;
        alloc_result_t want;
        gap = send_rush ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata = {2'b00, slot, pool, mode};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        allocator_predict(mode, pool, slot, st, grant);
        want.status = st;
        want.granted = grant;
        expected_results.insert(expected_results.size(), want);
        items_sent++;
        @(negedge clk);
    endtask

    // Waits until every predicted result has come out, then a few cycles more
    // so the block is idle before a register write or the end of the run.
    task automatic wait_for_results();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes one pool size register. Only called with the block idle.
    task automatic write_pool_size(input logic [CFG_AW-1:0] idx,
                                   input logic [SIZE_W-1:0] value);
        s_axis_tvalid = 1'b0;
        cfg_addr = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        set_pool_size(idx, value);
        held_slots[idx].delete();
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the checker.
    // ------------------------------------------------------------------------

    // The receiver draws a stall before every result and then stays ready
    // until one result transaction has been taken.
    initial
    begin : result_receiver
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = recv_rush ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Every result transaction is compared field by field with the oldest
    // prediction. Inputs only move at falling edges, so values read here are
    // the ones the block saw at this rising edge.
    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        logic [STATUS_W-1:0] got_status;
        logic [SLOT_W-1:0] got_index;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_status = m_axis_tdata[STATUS_W-1:0];
            got_index = m_axis_tdata[STATUS_W +: SLOT_W];
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", got_status, -1);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got_status !== want.status)
                begin
                    report_mismatch("status", got_status, want.status);
                end
                if (got_index !== want.granted)
                begin
                    report_mismatch("granted_index", got_index, want.granted);
                end
            end
        end
    end

    // Ends the run if no transaction moves on any port for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests. The checker compares every result with the model, so
    // the tests only choose the commands; the comments say what should come.
    // ------------------------------------------------------------------------

    // Right after reset every size is zero, so every pool is absent.
    task automatic test_absent_pools();
        status_t st;
        logic [SLOT_W-1:0] g;
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
        send_command(MODE_RELEASE, 2'd3, 10'd1023, st, g);
        wait_for_results();
    endtask

    // Sets the sizes used by the directed tests below. Pool 1 is written
    // beyond MAX_SLOTS and must saturate; pool 2 stays absent.
    task automatic setup_directed_sizes();
        write_pool_size(2'd0, 11'd1);
        write_pool_size(2'd1, 11'd2047);
        write_pool_size(2'd2, 11'd0);
        write_pool_size(2'd3, 11'd3);
    endtask

    // A one-slot pool: grant, empty, the range check ahead of the full check,
    // a refused second release, and the apply that returns the slot.
    task automatic test_single_slot_pool();
        status_t st;
        logic [SLOT_W-1:0] g;
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
        send_command(MODE_RELEASE, 2'd0, 10'd1, st, g);
        send_command(MODE_RELEASE, 2'd0, 10'd0, st, g);
        send_command(MODE_RELEASE, 2'd0, 10'd0, st, g);
        send_command(MODE_RELEASE, 2'd0, 10'd1023, st, g);
        send_command(MODE_APPLY, 2'd0, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
    endtask

    // The saturated pool hands out 1023 first and refuses a release that
    // would make free plus pending exceed its size.
    task automatic test_saturated_size();
        status_t st;
        logic [SLOT_W-1:0] g;
        send_command(MODE_ALLOC, 2'd1, 10'd0, st, g);
        send_command(MODE_RELEASE, 2'd1, 10'd1023, st, g);
        send_command(MODE_RELEASE, 2'd1, 10'd0, st, g);
        send_command(MODE_APPLY, 2'd2, 10'd512, st, g);
        send_command(MODE_ALLOC, 2'd1, 10'd0, st, g);
        // An absent pool wins over an out-of-range index.
        send_command(MODE_RELEASE, 2'd2, 10'd1023, st, g);
    endtask

    // Released indices return in release order, so the last one comes first.
    task automatic test_stack_order();
        status_t st;
        logic [SLOT_W-1:0] g;
        send_command(MODE_ALLOC, 2'd3, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd3, 10'd0, st, g);
        send_command(MODE_RELEASE, 2'd3, 10'd2, st, g);
        send_command(MODE_RELEASE, 2'd3, 10'd1, st, g);
        send_command(MODE_APPLY, 2'd3, 10'd1023, st, g);
        send_command(MODE_ALLOC, 2'd3, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd3, 10'd0, st, g);
    endtask

    // The unused mode does nothing and reports ok, whatever its fields hold.
    task automatic test_unused_mode();
        status_t st;
        logic [SLOT_W-1:0] g;
        send_command(MODE_NOP, 2'd3, 10'd1023, st, g);
    endtask

    // A size write drops the pool's pending list: after a resize the apply
    // must not push the released slot a second time.
    task automatic test_resize_clears_pending();
        status_t st;
        logic [SLOT_W-1:0] g;
        send_command(MODE_RELEASE, 2'd0, 10'd0, st, g);
        wait_for_results();
        write_pool_size(2'd0, 11'd2);
        send_command(MODE_APPLY, 2'd0, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
        send_command(MODE_ALLOC, 2'd0, 10'd0, st, g);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic in phases. Each phase writes all four sizes, mostly
    // small so that pools run empty and pending lists fill, with now and then
    // an absent pool or one at or beyond MAX_SLOTS. Most releases give back
    // indices the block really granted; the rest are random noise.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int sent;
        int r;
        int k;
        int limit;
        logic [POOL_W-1:0] pool;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] size;
        mode_t mode;
        status_t st;
        logic [SLOT_W-1:0] g;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_for_results();
            for (int p = 0; p < POOL_COUNT; p++)
            begin
                // The first two phases use the smallest and the largest size.
                if (random_phases == 0)
                begin
                    size = 11'd1;
                end
                else if (random_phases == 1)
                begin
                    size = SIZE_W'(MAX_SLOTS);
                end
                else
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        size = 11'd0;
                    else if (r == 1)
                        size = SIZE_W'($urandom_range(MAX_SLOTS, 2047));
                    else
                        size = SIZE_W'($urandom_range(1, 24));
                end
                write_pool_size(CFG_AW'(p), size);
            end
            send_rush = ($urandom_range(0, 3) == 0);
            recv_rush = ($urandom_range(0, 3) == 0);
            random_phases++;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Halfway through each phase the sender holds off until the
                // block has returned everything it owes.
                if (i == ITEMS_PER_PHASE / 2)
                begin
                    wait_for_results();
                end
                pool = POOL_W'($urandom_range(0, POOL_COUNT - 1));
                slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
                k = -1;
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    mode = MODE_ALLOC;
                end
                else if (r < 75)
                begin
                    mode = MODE_RELEASE;
                    if (held_slots[pool].size() != 0 && $urandom_range(0, 4) != 0)
                    begin
                        k = $urandom_range(0, held_slots[pool].size() - 1);
                        slot = held_slots[pool][k];
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        // Near the pool's own range, its size included.
                        limit = (pool_len_m[pool] > MAX_SLOTS - 1) ? MAX_SLOTS - 1
                                                                   : pool_len_m[pool];
                        slot = SLOT_W'($urandom_range(0, limit));
                    end
                end
                else if (r < 93)
                begin
                    mode = MODE_APPLY;
                end
                else
                begin
                    mode = MODE_NOP;
                end

                send_command(mode, pool, slot, st, g);
                sent++;
                if (mode == MODE_ALLOC && st == ST_OK)
                begin
                    held_slots[pool].insert(held_slots[pool].size(), g);
                end
                else if (k >= 0 && st == ST_OK)
                begin
                    held_slots[pool].delete(k);
                end
            end
        end
        send_rush = 1'b0;
        recv_rush = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        cfg_writes = 0;
        random_phases = 0;
        idle_cycles = 0;
        send_rush = 1'b0;
        recv_rush = 1'b0;
        for (int p = 0; p < POOL_COUNT; p++)
        begin
            pool_len_m[p] = 0;
            free_cnt_m[p] = 0;
            pending_cnt_m[p] = 0;
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_absent_pools();
        setup_directed_sizes();
        test_single_slot_pool();
        test_saturated_size();
        test_stack_order();
        test_unused_mode();
        test_resize_clears_pending();
        directed_items = items_sent;

        test_random_traffic();

        wait_for_results();
        $display("Sent %0d commands (%0d directed) with %0d pool size writes in %0d phases.",
                 items_sent, directed_items, cfg_writes, random_phases);
        $display("Checked %0d results, %0d mismatches.", results_seen, errors);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/ipa_pkg.sv
sv/ipa_ctrl.sv
sv/ipa_dp.sv
sv/index_pool_allocator_deferred_free.sv
sim/index_pool_allocator_deferred_free_test.sv
